FILE: design/pblep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pblep_pkg
// Shared constants and codes for the band-limited wave oscillator.
// ----------------------------------------------------------------------------
package pblep_pkg;

  localparam int PHASE_BITS_DEF = 24;
  localparam int OUT_BITS_DEF   = 24;

  localparam int          CFG_IDX_BITS = 2;
  localparam int unsigned RESET_STEP   = 32'd153791;
  localparam int unsigned RESET_DUTY   = 32'd8388608;

  localparam logic [CFG_IDX_BITS-1:0] REG_WAVE_MODE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_STEP = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_CYCLE = 2'd2;

  typedef enum logic [2:0] {
    MODE_SAW        = 3'd0,
    MODE_BLEP_SAW   = 3'd1,
    MODE_PULSE      = 3'd2,
    MODE_BLEP_PULSE = 3'd3,
    MODE_TRIANGLE   = 3'd4
  } mode_t;

  localparam mode_t RESET_MODE = MODE_BLEP_SAW;

  typedef enum logic [1:0] {
    EDGE_NONE   = 2'd0,
    EDGE_AFTER  = 2'd1,
    EDGE_BEFORE = 2'd2
  } edge_t;

endpackage

FILE: design/pblep_phase_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pblep_phase_if
// Phase channel: valid/ready handshake carrying one phase per beat.
// ----------------------------------------------------------------------------
interface pblep_phase_if #(
  parameter int PHASE_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [PHASE_BITS-1:0] phase_in;

  modport source (output valid, output phase_in, input ready);
  modport sink   (input valid, input phase_in, output ready);
endinterface

FILE: design/pblep_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pblep_sample_if
// Sample channel: valid/ready handshake carrying one signed sample per beat.
// ----------------------------------------------------------------------------
interface pblep_sample_if #(
  parameter int OUT_BITS = 24
);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: design/polyblep_wave_oscillator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyblep_wave_oscillator_core
// Stateless band-limited oscillator: phase in, waveform sample out.
// ----------------------------------------------------------------------------
// Takes one phase beat per clock and returns one sample beat per clock while
// the output is not stalled. The pipeline holds a setup stage, then one
// quotient bit per pipeline stage over OUT_BITS-4 stages, followed by a square
// stage, a residual stage and the output register. Each stage holds its own
// valid bit, so bubbles close up on a stall and input is still taken while a
// finished sample waits, as long as a stage is empty. Configuration is written
// through cfg_we/cfg_index/cfg_wdata; the user must write it only while no beat
// is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module polyblep_wave_oscillator_core
  import pblep_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int OUT_BITS   = OUT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PHASE_BITS-1:0]   cfg_wdata,
  pblep_phase_if.sink             in_ch,
  pblep_sample_if.source          out_ch
);

  localparam int FRAC = OUT_BITS - 4;
  localparam int VW   = FRAC + 3;
  localparam int EXT  = OUT_BITS - VW;
  localparam int SQ   = FRAC + 1;
  localparam int RS   = FRAC + 2;
  localparam int OS   = FRAC + 3;
  localparam int NST  = FRAC + 4;

  localparam logic signed [VW-1:0] Q_ONE   = {{(VW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};
  localparam logic signed [VW-1:0] Q_THREE = Q_ONE + (Q_ONE <<< 1);
  localparam logic [FRAC:0]        QU_ONE  = {1'b1, {FRAC{1'b0}}};

  typedef struct packed {
    logic signed [VW-1:0] base;
    edge_t                kind_a;
    edge_t                kind_b;
    logic                 neg_a;
  } ctl_t;

  // configuration
  logic [2:0]            wave_mode_r;
  logic [PHASE_BITS-1:0] phase_step_r;
  logic [PHASE_BITS-1:0] duty_cycle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_mode_r  <= RESET_MODE;
      phase_step_r <= PHASE_BITS'(RESET_STEP);
      duty_cycle_r <= PHASE_BITS'(RESET_DUTY);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAVE_MODE:  wave_mode_r  <= cfg_wdata[2:0];
        REG_PHASE_STEP: phase_step_r <= cfg_wdata;
        REG_DUTY_CYCLE: duty_cycle_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid/ready chain
  logic [NST-1:0] vld_r;
  logic [NST:0]   rdy;
  logic [NST-1:0] vin;

  always_comb begin
    rdy[NST] = out_ch.ready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    vin[0] = in_ch.valid;
    for (int i = 1; i < NST; i++) begin
      vin[i] = vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vin[i];
        end
      end
    end
  end

  assign in_ch.ready = rdy[0];

  // edge classification
  function automatic edge_t edge_kind(input logic [PHASE_BITS-1:0] t,
                                      input logic [PHASE_BITS-1:0] dt);
    logic [PHASE_BITS:0] lim;
    begin
      lim = {1'b1, {PHASE_BITS{1'b0}}} - {1'b0, dt};
      if (t < dt) begin
        edge_kind = EDGE_AFTER;
      end else if ((dt != '0) && ({1'b0, t} > lim)) begin
        edge_kind = EDGE_BEFORE;
      end else begin
        edge_kind = EDGE_NONE;
      end
    end
  endfunction

  function automatic logic [PHASE_BITS-1:0] edge_num(input logic [PHASE_BITS-1:0] t,
                                                     input edge_t kind);
    begin
      if (kind == EDGE_BEFORE) begin
        edge_num = ~t + PHASE_BITS'(1);
      end else begin
        edge_num = t;
      end
    end
  endfunction

  // setup stage
  logic [PHASE_BITS-1:0]      p;
  logic [PHASE_BITS-1:0]      t_b;
  logic [PHASE_BITS+FRAC:0]   wide1;
  logic [PHASE_BITS+FRAC+1:0] wide2;
  logic [FRAC:0]              sp1;
  logic [FRAC+1:0]            sp2;
  edge_t                      ka;
  edge_t                      kb;
  ctl_t                       ctl0;

  always_comb begin
    p     = in_ch.phase_in;
    t_b   = p - duty_cycle_r;
    wide1 = {p, {(FRAC+1){1'b0}}};
    wide2 = {p, {(FRAC+2){1'b0}}};
    sp1   = wide1[PHASE_BITS+FRAC:PHASE_BITS];
    sp2   = wide2[PHASE_BITS+FRAC+1:PHASE_BITS];
    ka    = edge_kind(p, phase_step_r);
    kb    = edge_kind(t_b, phase_step_r);
    ctl0  = '{base: '0, kind_a: EDGE_NONE, kind_b: EDGE_NONE, neg_a: 1'b0};
    case (mode_t'(wave_mode_r))
      MODE_SAW: begin
        ctl0.base = $signed({2'b00, sp1}) - Q_ONE;
      end
      MODE_BLEP_SAW: begin
        ctl0.base   = $signed({2'b00, sp1}) - Q_ONE;
        ctl0.kind_a = ka;
        ctl0.neg_a  = 1'b1;
      end
      MODE_PULSE: begin
        ctl0.base = (p < duty_cycle_r) ? Q_ONE : -Q_ONE;
      end
      MODE_BLEP_PULSE: begin
        ctl0.base   = (p < duty_cycle_r) ? Q_ONE : -Q_ONE;
        ctl0.kind_a = ka;
        ctl0.kind_b = kb;
      end
      MODE_TRIANGLE: begin
        if (!p[PHASE_BITS-1]) begin
          ctl0.base = $signed({1'b0, sp2}) - Q_ONE;
        end else begin
          ctl0.base = Q_THREE - $signed({1'b0, sp2});
        end
      end
      default: ;
    endcase
  end

  // divider pipeline: one quotient bit per stage
  ctl_t                  ctl_r   [0:FRAC];
  logic [PHASE_BITS-1:0] rem_a_r [0:FRAC];
  logic [PHASE_BITS-1:0] rem_b_r [0:FRAC];
  logic [FRAC-1:0]       q_a_r   [0:FRAC];
  logic [FRAC-1:0]       q_b_r   [0:FRAC];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ctl_r[0]   <= ctl0;
      rem_a_r[0] <= edge_num(p, ka);
      rem_b_r[0] <= edge_num(t_b, kb);
      q_a_r[0]   <= '0;
      q_b_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= FRAC; k++) begin : g_div
    logic [PHASE_BITS:0] sh_a;
    logic [PHASE_BITS:0] sh_b;
    logic                ge_a;
    logic                ge_b;
    logic [PHASE_BITS:0] df_a;
    logic [PHASE_BITS:0] df_b;

    always_comb begin
      sh_a = {rem_a_r[k-1], 1'b0};
      sh_b = {rem_b_r[k-1], 1'b0};
      ge_a = sh_a >= {1'b0, phase_step_r};
      ge_b = sh_b >= {1'b0, phase_step_r};
      df_a = ge_a ? (sh_a - {1'b0, phase_step_r}) : sh_a;
      df_b = ge_b ? (sh_b - {1'b0, phase_step_r}) : sh_b;
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        ctl_r[k]   <= ctl_r[k-1];
        rem_a_r[k] <= df_a[PHASE_BITS-1:0];
        rem_b_r[k] <= df_b[PHASE_BITS-1:0];
        q_a_r[k]   <= {q_a_r[k-1][FRAC-2:0], ge_a};
        q_b_r[k]   <= {q_b_r[k-1][FRAC-2:0], ge_b};
      end
    end
  end

  // square stage
  logic [FRAC:0]     m_a;
  logic [FRAC:0]     m_b;
  logic [2*FRAC+1:0] pr_a;
  logic [2*FRAC+1:0] pr_b;
  ctl_t              ctl_sq_r;
  logic [FRAC-1:0]   q_a_sq_r;
  logic [FRAC-1:0]   q_b_sq_r;
  logic [FRAC:0]     sq_a_r;
  logic [FRAC:0]     sq_b_r;

  always_comb begin
    m_a  = (ctl_r[FRAC].kind_a == EDGE_AFTER) ? {1'b0, q_a_r[FRAC]}
                                              : QU_ONE - {1'b0, q_a_r[FRAC]};
    m_b  = (ctl_r[FRAC].kind_b == EDGE_AFTER) ? {1'b0, q_b_r[FRAC]}
                                              : QU_ONE - {1'b0, q_b_r[FRAC]};
    pr_a = m_a * m_a;
    pr_b = m_b * m_b;
  end

  always_ff @(posedge clk) begin
    if (rdy[SQ]) begin
      ctl_sq_r <= ctl_r[FRAC];
      q_a_sq_r <= q_a_r[FRAC];
      q_b_sq_r <= q_b_r[FRAC];
      sq_a_r   <= pr_a[2*FRAC:FRAC];
      sq_b_r   <= pr_b[2*FRAC:FRAC];
    end
  end

  // residual stage
  function automatic logic signed [VW-1:0] residual(input edge_t kind,
                                                    input logic [FRAC-1:0] q,
                                                    input logic [FRAC:0] sq);
    begin
      case (kind)
        EDGE_AFTER:  residual = $signed({2'b00, q, 1'b0}) - $signed({2'b00, sq}) - Q_ONE;
        EDGE_BEFORE: residual = $signed({2'b00, sq});
        default:     residual = '0;
      endcase
    end
  endfunction

  logic signed [VW-1:0] base_rs_r;
  logic                 neg_a_rs_r;
  logic signed [VW-1:0] res_a_r;
  logic signed [VW-1:0] res_b_r;

  always_ff @(posedge clk) begin
    if (rdy[RS]) begin
      base_rs_r  <= ctl_sq_r.base;
      neg_a_rs_r <= ctl_sq_r.neg_a;
      res_a_r    <= residual(ctl_sq_r.kind_a, q_a_sq_r, sq_a_r);
      res_b_r    <= residual(ctl_sq_r.kind_b, q_b_sq_r, sq_b_r);
    end
  end

  // output stage: the sum stays within three units, so no clipping occurs
  logic signed [OUT_BITS-1:0] base_x;
  logic signed [OUT_BITS-1:0] res_a_x;
  logic signed [OUT_BITS-1:0] res_b_x;
  logic signed [OUT_BITS-1:0] sum_nxt;
  logic signed [OUT_BITS-1:0] sample_r;

  always_comb begin
    base_x  = {{EXT{base_rs_r[VW-1]}}, base_rs_r};
    res_a_x = {{EXT{res_a_r[VW-1]}}, res_a_r};
    res_b_x = {{EXT{res_b_r[VW-1]}}, res_b_r};
    sum_nxt = (neg_a_rs_r ? (base_x - res_a_x) : (base_x + res_a_x)) - res_b_x;
  end

  always_ff @(posedge clk) begin
    if (rdy[OS]) begin
      sample_r <= sum_nxt;
    end
  end

  assign out_ch.valid      = vld_r[OS];
  assign out_ch.sample_out = sample_r;

endmodule
